// ===== hw/rtl/crkp_pkg.sv =====
// shared types, constants and helpers for the keyframe path core
package crkp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PHASE_W   = FRAC_BITS + 1;
    localparam int WGT_W     = FRAC_BITS + 5;
    localparam int OPND_W    = COORD_W + 1;
    localparam int PROD_W    = WGT_W + OPND_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SHR_W     = ACC_W - FRAC_BITS - 1;
    localparam int NUM_TERMS = 8;
    localparam int STEP_W    = 4;
    localparam int DIVC_W    = 5;

    localparam logic [PHASE_W-1:0] PHASE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_JUMP = 2'd2;

    localparam logic CFG_NUM_KEYS = 1'b0;
    localparam logic CFG_FREEZE   = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]      duration;
        logic [2:0][COORD_W-1:0] end_p;
        logic [2:0][COORD_W-1:0] start_p;
    } key_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JUMP,
        S_ADV,
        S_CUR,
        S_PREV,
        S_NEXT,
        S_DIV,
        S_SQ,
        S_CUBE,
        S_MAC,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        RD_SLOT,
        RD_PLAY,
        RD_ADV,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    do_load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    jump_set;
        logic    adv;
        logic    cur_latch;
        logic    prev_latch;
        logic    next_latch;
        logic    sq;
        logic    cube;
        logic    mac_start;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mac_done;
    } dp_stat_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v[SHR_W-1:COORD_W-1] == '0 || v[SHR_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else if (v[SHR_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ===== hw/rtl/catmull_rom_keyframe_path_core.sv =====
// top level of the looping catmull-rom keyframe path core
// A load transfer writes one keyframe slot and restarts playback at keyframe 0; a jump
// transfer gives no result; a tick transfer gives one pose, its span set by the 16-step
// restoring phase divider and the eight-term multiply-accumulate that runs on each of
// the three axes with shared weights, after four reads of the keyframe table through
// its single read port, and the core is ready for the next item in the cycle after it
// loads the pose. One item is in work at a time; a finished pose waits in the output
// registers while the next item is taken. The keyframe table is not cleared by reset
// and a slot must be loaded before playback reads it.
module catmull_rom_keyframe_path_core #(
    parameter int MAX_KEYS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [3:0]         key_index,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic [31:0]        duration,
    input  logic [31:0]        step_time,
    input  logic [16:0]        progress,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic [3:0]         current_key,
    output logic [16:0]        phase,
    output logic               wrapped,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);
    import crkp_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    crkp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    crkp_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .key_index   (key_index),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_z       (end_z),
        .duration    (duration),
        .step_time   (step_time),
        .progress    (progress),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .current_key (current_key),
        .phase       (phase),
        .wrapped     (wrapped)
    );

endmodule

// ===== hw/rtl/crkp_ram.sv =====
// generic single write port, single read port ram with registered read
module crkp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hw/rtl/crkp_ctrl.sv =====
// controller state machine sequencing load, jump and tick
module crkp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    output logic              out_valid,
    input  logic              out_ready,
    output crkp_pkg::dp_cmd_t dp_cmd,
    input  crkp_pkg::dp_stat_t dp_stat
);
    import crkp_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (dp_cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK: state_next = S_ADV;
                        CMD_JUMP: state_next = S_JUMP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_JUMP: state_next = S_IDLE;
            S_ADV:  state_next = S_CUR;
            S_CUR:  state_next = S_PREV;
            S_PREV: state_next = S_NEXT;
            S_NEXT: state_next = S_DIV;
            S_DIV:
            begin
                if (dp_stat.div_done)
                    state_next = S_SQ;
            end
            S_SQ:   state_next = S_CUBE;
            S_CUBE: state_next = S_MAC;
            S_MAC:
            begin
                if (dp_stat.mac_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dp_cmd   = '0;
        dp_cmd.rd_sel = RD_PLAY;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    case (command)
                        CMD_LOAD: dp_cmd.do_load = 1'b1;
                        CMD_TICK:
                        begin
                            dp_cmd.rd_en  = 1'b1;
                            dp_cmd.rd_sel = RD_PLAY;
                        end
                        CMD_JUMP:
                        begin
                            dp_cmd.rd_en  = 1'b1;
                            dp_cmd.rd_sel = RD_SLOT;
                        end
                        default: dp_cmd.accept = 1'b1;
                    endcase
                end
            end
            S_JUMP: dp_cmd.jump_set = 1'b1;
            S_ADV:
            begin
                dp_cmd.adv    = 1'b1;
                dp_cmd.rd_en  = 1'b1;
                dp_cmd.rd_sel = RD_ADV;
            end
            S_CUR:
            begin
                dp_cmd.cur_latch = 1'b1;
                dp_cmd.rd_en     = 1'b1;
                dp_cmd.rd_sel    = RD_PREV;
            end
            S_PREV:
            begin
                dp_cmd.prev_latch = 1'b1;
                dp_cmd.rd_en      = 1'b1;
                dp_cmd.rd_sel     = RD_NEXT;
            end
            S_NEXT: dp_cmd.next_latch = 1'b1;
            S_SQ:   dp_cmd.sq = 1'b1;
            S_CUBE:
            begin
                dp_cmd.cube      = 1'b1;
                dp_cmd.mac_start = 1'b1;
            end
            S_OUT:  dp_cmd.out_load = !out_valid_reg || out_ready;
            default: dp_cmd.rd_sel = RD_PLAY;
        endcase
    end

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && command == CMD_TICK) |=> state_reg == S_ADV)
        else $error("tick transfer did not start the advance step");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished pose not presented");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !dp_stat.div_done) |=> state_reg == S_DIV)
        else $error("left divide wait before the phase was ready");
`endif

endmodule

// ===== hw/rtl/crkp_datapath.sv =====
// keyframe table, play state, phase divider and shared cubic multiply-accumulate
module crkp_datapath #(
    parameter int MAX_KEYS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  crkp_pkg::dp_cmd_t  dp_cmd,
    output crkp_pkg::dp_stat_t dp_stat,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic [3:0]         key_index,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic [31:0]        duration,
    input  logic [31:0]        step_time,
    input  logic [16:0]        progress,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic [3:0]         current_key,
    output logic [16:0]        phase,
    output logic               wrapped
);
    import crkp_pkg::*;

    localparam int KW = $clog2(MAX_KEYS);
    localparam int NW = KW + 1;

    function automatic logic [KW-1:0] key_slot(input logic [3:0] k);
        logic [4:0] v;
        v = {1'b0, k};
        for (int i = 0; i < 8; i++)
        begin
            if (int'(v) >= MAX_KEYS)
                v = v - 5'(MAX_KEYS);
        end
        return KW'(v);
    endfunction

    // configuration
    logic [4:0] nk_reg;
    logic       freeze_reg;
    logic [8:0] n_wide;
    logic [NW-1:0] n;

    // play state and latched item
    logic [KW-1:0]        play_index_reg;
    logic [31:0]          play_time_reg;
    logic [KW-1:0]        slot_reg;
    logic [PHASE_W-1:0]   prog_reg;
    logic [31:0]          dt_reg;
    logic                 wrapped_reg;

    // table
    key_entry_t  wr_entry, rd_entry;
    logic [KW-1:0] raddr;

    // advance
    logic [32:0]   sum;
    logic [32:0]   t_left;
    logic          finished;
    logic          on_last;
    logic [31:0]   time_next;
    logic [KW-1:0] index_next;
    logic [KW-1:0] prev_idx, next_idx;

    // divider
    logic [31:0]        dur_reg;
    logic [31:0]        rem_reg, rem_next;
    logic [PHASE_W-1:0] q_reg, q_next;
    logic [DIVC_W-1:0]  div_cnt_reg;
    logic [32:0]        rem_shl;
    logic               div_ge;

    // powers and weights
    logic [PHASE_W-1:0]     x2_reg, x3_reg;
    logic [2*PHASE_W-1:0]   sq_full, cu_full;
    logic [PHASE_W+31:0]    jump_full;
    logic signed [WGT_W-1:0] xs, x2s, x3s, ones;
    logic signed [WGT_W-1:0] wt [NUM_TERMS];
    logic signed [WGT_W-1:0] w_sel;

    // multiply-accumulate per axis
    logic signed [31:0]       p0_reg [3];
    logic signed [31:0]       p1_reg [3];
    logic signed [31:0]       p2_reg [3];
    logic signed [31:0]       p3_reg [3];
    logic signed [OPND_W-1:0] op_sel [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [ACC_W-1:0]  acc_pos_reg [3];
    logic signed [ACC_W-1:0]  acc_vel_reg [3];
    logic signed [SHR_W-1:0]  shr_pos [3];
    logic signed [SHR_W-1:0]  shr_vel [3];
    logic [STEP_W-1:0]        step_reg;
    logic                     prod_valid_reg;
    logic                     prod_vel_reg;

    always_comb
    begin
        if (nk_reg == '0)
            n_wide = 9'd1;
        else if (int'(nk_reg) > MAX_KEYS)
            n_wide = 9'(MAX_KEYS);
        else
            n_wide = {4'b0, nk_reg};
        n = NW'(n_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nk_reg     <= 5'd1;
            freeze_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_KEYS: nk_reg <= cfg_data;
                CFG_FREEZE:   freeze_reg <= cfg_data[0];
                default:      nk_reg <= nk_reg;
            endcase
        end
    end

    // table ram
    always_comb
    begin
        wr_entry.duration   = duration;
        wr_entry.start_p[0] = start_x;
        wr_entry.start_p[1] = start_y;
        wr_entry.start_p[2] = start_z;
        wr_entry.end_p[0]   = end_x;
        wr_entry.end_p[1]   = end_y;
        wr_entry.end_p[2]   = end_z;
    end

    always_comb
    begin
        sum        = {1'b0, play_time_reg} + {1'b0, dt_reg};
        finished   = {1'b0, rd_entry.duration} < sum;
        on_last    = ({1'b0, play_index_reg} + NW'(1)) >= n;
        t_left     = finished ? sum - {1'b0, rd_entry.duration} : sum;
        time_next  = t_left[32] ? '1 : t_left[31:0];
        if (!finished)
            index_next = play_index_reg;
        else if (on_last)
            index_next = '0;
        else
            index_next = play_index_reg + KW'(1);
        prev_idx = (play_index_reg == '0) ? KW'(n - NW'(1)) : play_index_reg - KW'(1);
        next_idx = on_last ? '0 : play_index_reg + KW'(1);
    end

    always_comb
    begin
        case (dp_cmd.rd_sel)
            RD_SLOT: raddr = key_slot(key_index);
            RD_PLAY: raddr = play_index_reg;
            RD_ADV:  raddr = index_next;
            RD_PREV: raddr = prev_idx;
            RD_NEXT: raddr = next_idx;
            default: raddr = play_index_reg;
        endcase
    end

    crkp_ram #(
        .WIDTH ($bits(key_entry_t)),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (dp_cmd.do_load),
        .waddr (key_slot(key_index)),
        .wdata (wr_entry),
        .re    (dp_cmd.rd_en),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    assign jump_full = prog_reg * rd_entry.duration;

    // play state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_index_reg <= '0;
            play_time_reg  <= '0;
        end
        else if (dp_cmd.do_load)
        begin
            play_index_reg <= '0;
            play_time_reg  <= '0;
        end
        else if (dp_cmd.jump_set)
        begin
            play_index_reg <= slot_reg;
            play_time_reg  <= jump_full[FRAC_BITS+31:FRAC_BITS];
        end
        else if (dp_cmd.adv)
        begin
            play_index_reg <= index_next;
            play_time_reg  <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            slot_reg <= key_slot(key_index);
            prog_reg <= (progress > PHASE_ONE) ? PHASE_ONE : progress;
            dt_reg   <= freeze_reg ? '0 : step_time;
        end
        if (dp_cmd.adv)
            wrapped_reg <= finished && on_last;
    end

    // restoring phase divider, one quotient bit per cycle
    always_comb
    begin
        rem_shl  = {rem_reg, 1'b0};
        div_ge   = rem_shl >= {1'b0, dur_reg};
        rem_next = div_ge ? 32'(rem_shl - {1'b0, dur_reg}) : rem_shl[31:0];
        q_next   = {q_reg[FRAC_BITS-1:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (dp_cmd.cur_latch)
        begin
            if (rd_entry.duration == '0 || play_time_reg >= rd_entry.duration)
                div_cnt_reg <= '0;
            else
                div_cnt_reg <= DIVC_W'(FRAC_BITS);
        end
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.cur_latch)
        begin
            dur_reg <= rd_entry.duration;
            rem_reg <= play_time_reg;
            if (rd_entry.duration == '0 || play_time_reg >= rd_entry.duration)
                q_reg <= PHASE_ONE;
            else
                q_reg <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // phase powers
    assign sq_full = q_reg * q_reg;
    assign cu_full = x2_reg * q_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.sq)
            x2_reg <= sq_full[FRAC_BITS+PHASE_W-1:FRAC_BITS];
        if (dp_cmd.cube)
            x3_reg <= cu_full[FRAC_BITS+PHASE_W-1:FRAC_BITS];
    end

    // hermite weights, position set then derivative set
    always_comb
    begin
        xs    = $signed(WGT_W'(q_reg));
        x2s   = $signed(WGT_W'(x2_reg));
        x3s   = $signed(WGT_W'(x3_reg));
        ones  = $signed(WGT_W'(PHASE_ONE));
        wt[0] = (x3s <<< 1) - (x2s <<< 1) - x2s + ones;
        wt[1] = (x2s <<< 1) + x2s - (x3s <<< 1);
        wt[2] = x3s - (x2s <<< 1) + xs;
        wt[3] = x3s - x2s;
        wt[4] = (x2s <<< 2) + (x2s <<< 1) - (xs <<< 2) - (xs <<< 1);
        wt[5] = (xs <<< 2) + (xs <<< 1) - (x2s <<< 2) - (x2s <<< 1);
        wt[6] = (x2s <<< 1) + x2s - (xs <<< 2) + ones;
        wt[7] = (x2s <<< 1) + x2s - (xs <<< 1);
        w_sel = wt[step_reg[2:0]];
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        always_comb
        begin
            case (step_reg[1:0])
                2'd0:    op_sel[a] = $signed({p1_reg[a], 1'b0});
                2'd1:    op_sel[a] = $signed({p2_reg[a], 1'b0});
                2'd2:    op_sel[a] = OPND_W'(p2_reg[a]) - OPND_W'(p0_reg[a]);
                default: op_sel[a] = OPND_W'(p3_reg[a]) - OPND_W'(p1_reg[a]);
            endcase
            shr_pos[a] = SHR_W'(acc_pos_reg[a] >>> (FRAC_BITS + 1));
            shr_vel[a] = SHR_W'(acc_vel_reg[a] >>> (FRAC_BITS + 1));
        end

        always_ff @(posedge clk)
        begin
            if (dp_cmd.cur_latch)
            begin
                p1_reg[a] <= $signed(rd_entry.start_p[a]);
                p2_reg[a] <= $signed(rd_entry.end_p[a]);
            end
            if (dp_cmd.prev_latch)
                p0_reg[a] <= $signed(rd_entry.start_p[a]);
            if (dp_cmd.next_latch)
                p3_reg[a] <= $signed(rd_entry.end_p[a]);
            if (step_reg < STEP_W'(NUM_TERMS))
                prod_reg[a] <= w_sel * op_sel[a];
            if (dp_cmd.mac_start)
            begin
                acc_pos_reg[a] <= '0;
                acc_vel_reg[a] <= '0;
            end
            else if (prod_valid_reg)
            begin
                if (prod_vel_reg)
                    acc_vel_reg[a] <= acc_vel_reg[a] + ACC_W'(prod_reg[a]);
                else
                    acc_pos_reg[a] <= acc_pos_reg[a] + ACC_W'(prod_reg[a]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_W'(NUM_TERMS);
            prod_valid_reg <= 1'b0;
            prod_vel_reg   <= 1'b0;
        end
        else if (dp_cmd.mac_start)
        begin
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
        end
        else if (step_reg < STEP_W'(NUM_TERMS))
        begin
            step_reg       <= step_reg + STEP_W'(1);
            prod_valid_reg <= 1'b1;
            prod_vel_reg   <= step_reg[2];
        end
        else
            prod_valid_reg <= 1'b0;
    end

    assign dp_stat.div_done = (div_cnt_reg == '0);
    assign dp_stat.mac_done = (step_reg == STEP_W'(NUM_TERMS)) && !prod_valid_reg;

    // result registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            pos_x       <= sat32(shr_pos[0]);
            pos_y       <= sat32(shr_pos[1]);
            pos_z       <= sat32(shr_pos[2]);
            vel_x       <= sat32(shr_vel[0]);
            vel_y       <= sat32(shr_vel[1]);
            vel_z       <= sat32(shr_vel[2]);
            current_key <= 4'(play_index_reg);
            phase       <= q_reg;
            wrapped     <= wrapped_reg;
        end
    end

endmodule
